// ----- src/lscn_pkg.sv -----
`timescale 1ns / 1ps

package lscn_pkg;

    // Widths fixed by the item fields.
    localparam int OP_W     = 2;
    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 16;
    localparam int PCT_W    = 16;
    localparam int STATUS_W = 2;

    // Background-subtracted sample and calibration levels.
    localparam int NET_W  = SAMPLE_W + 1;
    // Span and numerator before scaling.
    localparam int SPAN_W = NET_W + 1;
    // Numerator scaled by 100, signed, and its magnitude.
    localparam int PROD_W = SPAN_W + 7;
    localparam int MAG_W  = PROD_W - 1;
    // Divider iteration counter.
    localparam int CNT_W  = $clog2(MAG_W);

    // Entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Opcodes.
    localparam logic [OP_W-1:0] OP_BACKGROUND = 2'd0;
    localparam logic [OP_W-1:0] OP_CAL_FIRST  = 2'd1;
    localparam logic [OP_W-1:0] OP_CAL_UPDATE = 2'd2;
    localparam logic [OP_W-1:0] OP_MEASURE    = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_SPAN = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT       = 2'd2;

    // Saturation bounds as quotient magnitudes.
    localparam logic [MAG_W-1:0] POS_LIMIT = 24'd32767;
    localparam logic [MAG_W-1:0] NEG_LIMIT = 24'd32768;
    localparam logic [PCT_W-1:0] PCT_MAX   = 16'h7FFF;
    localparam logic [PCT_W-1:0] PCT_MIN   = 16'h8000;

    // One classified measurement, ready for division.
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [SPAN_W-1:0] span;
        logic             zero;
        logic [CH_W-1:0]  ch;
    } t_meas;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_FINISH
    } t_back_state;

endpackage

// ----- src/lscn_intf.sv -----
`timescale 1ns / 1ps

// Request channel carrying one sensor item.
interface lscn_in_if;
    logic                          valid;
    logic                          ready;
    logic [lscn_pkg::OP_W-1:0]     opcode;
    logic [lscn_pkg::CH_W-1:0]     channel;
    logic [lscn_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output opcode, output channel, output sample,
                    input ready);
    modport sink (input valid, input opcode, input channel, input sample,
                  output ready);
endinterface

// Result channel carrying one normalized reading.
interface lscn_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [lscn_pkg::PCT_W-1:0] percent;
    logic [lscn_pkg::STATUS_W-1:0] status;
    logic [lscn_pkg::CH_W-1:0]     result_channel;

    modport source (output valid, output percent, output status,
                    output result_channel, input ready);
    modport sink (input valid, input percent, input status,
                  input result_channel, output ready);
endinterface

// ----- src/line_sensor_calibrate_normalize.sv -----
`timescale 1ns / 1ps
// Channel    Dir  Fields                              Results
// i_item     in   opcode, channel, sample             none, or one for a measurement
// o_result   out  percent, status, result_channel     one per in-range measurement
//
// Background and calibration requests retire one per cycle in the front stage, unless a
// measurement held ahead of them waits on a full queue. A measurement passes through the
// front holding stage, the queue, 24 iterations of the shared restoring divider, and the
// hand-off to the output register. A zero span skips the divider. The back end takes no new
// measurement from the queue until the last one has been handed to the output register.
// Reset is synchronous and active low; it clears all per-channel levels to zero.
// A stalled output holds the result; the two-entry queue lets the front keep working.

module line_sensor_calibrate_normalize #(
    parameter int CHANNELS    = 6,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lscn_in_if.sink     i_item,
    lscn_out_if.source  o_result
);

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    lscn_pkg::t_meas q_push_data;
    lscn_pkg::t_meas q_pop_data;

    lscn_front #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    lscn_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_full      (q_full),
        .o_empty     (q_empty)
    );

    lscn_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (q_pop_data),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .o_result (o_result)
    );

    // The front never writes a full queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(q_push && q_full))
        else $error("measurement pushed into a full queue");

    // The back never takes from an empty queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(q_pop && q_empty))
        else $error("measurement popped from an empty queue");

    // A zero span always reports a zero reading.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status == lscn_pkg::STATUS_ZERO_SPAN)
            |-> (o_result.percent == '0))
        else $error("zero span result with nonzero reading");

    // A saturated result sits on one of the two bounds.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status == lscn_pkg::STATUS_SAT)
            |-> (o_result.percent == $signed(lscn_pkg::PCT_MAX)
                 || o_result.percent == $signed(lscn_pkg::PCT_MIN)))
        else $error("saturated result off the bounds");

endmodule

// ----- src/lscn_front.sv -----
`timescale 1ns / 1ps

module lscn_front #(
    parameter int CHANNELS    = 6,
    parameter int SAMPLE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lscn_in_if.sink           i_item,
    input  logic              i_full,
    output logic              o_push,
    output lscn_pkg::t_meas   o_push_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [lscn_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
        lscn_pkg::SAMPLE_W'((17'd1 << SAMPLE_BITS) - 17'd1);

    // Input holding stage.
    logic                              r_hold_v;
    logic [lscn_pkg::OP_W-1:0]         r_op;
    logic [lscn_pkg::CH_W-1:0]         r_ch;
    logic [lscn_pkg::SAMPLE_W-1:0]     r_sample;

    // Per-channel levels.
    logic [lscn_pkg::SAMPLE_W-1:0]     r_bg  [CHANNELS];
    logic signed [lscn_pkg::NET_W-1:0] r_min [CHANNELS];
    logic signed [lscn_pkg::NET_W-1:0] r_max [CHANNELS];

    logic [IDX_W-1:0]                  idx;
    logic                              ch_ok;
    logic                              go;
    logic [lscn_pkg::SAMPLE_W-1:0]     smp;
    logic [lscn_pkg::SAMPLE_W-1:0]     bg;
    logic signed [lscn_pkg::NET_W-1:0] cur_min;
    logic signed [lscn_pkg::NET_W-1:0] cur_max;
    logic signed [lscn_pkg::NET_W-1:0] net;
    logic signed [lscn_pkg::SPAN_W-1:0] numer;
    logic signed [lscn_pkg::SPAN_W-1:0] span;
    logic signed [lscn_pkg::PROD_W-1:0] numer_x;
    logic signed [lscn_pkg::PROD_W-1:0] prod;
    logic signed [lscn_pkg::PROD_W-1:0] prod_abs;

    // Read the levels of the held channel.
    assign idx     = IDX_W'(r_ch);
    assign ch_ok   = (5'(r_ch) < 5'(CHANNELS));
    assign smp     = r_sample & SAMPLE_MASK;
    assign bg      = r_bg[idx];
    assign cur_min = r_min[idx];
    assign cur_max = r_max[idx];
    assign net     = $signed({1'b0, smp}) - $signed({1'b0, bg});

    // The held item retires unless it is an in-range measurement facing a full queue.
    // No request is taken while reset is asserted.
    assign go = r_hold_v && (!ch_ok || (r_op != lscn_pkg::OP_MEASURE) || !i_full);
    assign i_item.ready = i_rst_n && (!r_hold_v || go);

    // Measurement operands: scaled numerator and calibration span.
    assign numer    = lscn_pkg::SPAN_W'(net) - lscn_pkg::SPAN_W'(cur_min);
    assign span     = lscn_pkg::SPAN_W'(cur_max) - lscn_pkg::SPAN_W'(cur_min);
    assign numer_x  = lscn_pkg::PROD_W'(numer);
    assign prod     = (numer_x <<< 6) + (numer_x <<< 5) + (numer_x <<< 2);
    assign prod_abs = prod[lscn_pkg::PROD_W-1] ? -prod : prod;

    assign o_push           = go && ch_ok && (r_op == lscn_pkg::OP_MEASURE);
    assign o_push_data.neg  = prod[lscn_pkg::PROD_W-1];
    assign o_push_data.mag  = prod_abs[lscn_pkg::MAG_W-1:0];
    assign o_push_data.span = span;
    assign o_push_data.zero = (span == '0);
    assign o_push_data.ch   = r_ch;

    // Holding stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_hold_v <= 1'b1;
        end else if (go) begin
            r_hold_v <= 1'b0;
        end
    end

    // Holding stage payload.
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_op     <= i_item.opcode;
            r_ch     <= i_item.channel;
            r_sample <= i_item.sample;
        end
    end

    // Background capture and calibration updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_bg[i]  <= '0;
                r_min[i] <= '0;
                r_max[i] <= '0;
            end
        end else if (go && ch_ok) begin
            unique case (r_op)
                lscn_pkg::OP_BACKGROUND: begin
                    r_bg[idx] <= smp;
                end
                lscn_pkg::OP_CAL_FIRST: begin
                    r_min[idx] <= net;
                    r_max[idx] <= net;
                end
                lscn_pkg::OP_CAL_UPDATE: begin
                    if (net > cur_max) begin
                        r_max[idx] <= net;
                    end else if (net < cur_min) begin
                        r_min[idx] <= net;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- src/lscn_queue.sv -----
`timescale 1ns / 1ps

module lscn_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lscn_pkg::t_meas i_push_data,
    input  logic            i_pop,
    output lscn_pkg::t_meas o_pop_data,
    output logic            o_full,
    output logic            o_empty
);

    lscn_pkg::t_meas                r_entry [lscn_pkg::QUEUE_DEPTH];
    logic [lscn_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [lscn_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [lscn_pkg::QPTR_W:0]      r_count;

    assign o_full     = (r_count == (lscn_pkg::QPTR_W + 1)'(lscn_pkg::QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_entry[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ----- src/lscn_back.sv -----
`timescale 1ns / 1ps

module lscn_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lscn_pkg::t_meas i_entry,
    input  logic            i_empty,
    output logic            o_pop,
    lscn_out_if.source      o_result
);

    lscn_pkg::t_back_state            r_state;
    lscn_pkg::t_back_state            n_state;

    logic [lscn_pkg::SPAN_W-1:0]      r_rem;
    logic [lscn_pkg::MAG_W-1:0]       r_quo;
    logic [lscn_pkg::SPAN_W-1:0]      r_div;
    logic                             r_neg;
    logic                             r_zero;
    logic [lscn_pkg::CH_W-1:0]        r_ch;
    logic [lscn_pkg::CNT_W-1:0]       r_cnt;

    logic                             r_out_valid;
    logic [lscn_pkg::PCT_W-1:0]       r_pct;
    logic [lscn_pkg::STATUS_W-1:0]    r_status;
    logic [lscn_pkg::CH_W-1:0]        r_out_ch;

    logic                             load_out;
    logic [lscn_pkg::SPAN_W:0]        trial;
    logic                             fits;
    logic [lscn_pkg::SPAN_W:0]        diff;
    logic                             pos_sat;
    logic                             neg_sat;
    logic [lscn_pkg::PCT_W-1:0]       pct;
    logic [lscn_pkg::STATUS_W-1:0]    status;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lscn_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    n_state = i_entry.zero ? lscn_pkg::BK_FINISH : lscn_pkg::BK_DIVIDE;
                end
            end
            lscn_pkg::BK_DIVIDE: begin
                if (r_cnt == lscn_pkg::CNT_W'(lscn_pkg::MAG_W - 1)) begin
                    n_state = lscn_pkg::BK_FINISH;
                end
            end
            lscn_pkg::BK_FINISH: begin
                if (load_out) begin
                    n_state = lscn_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = lscn_pkg::BK_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            lscn_pkg::BK_IDLE:   o_pop    = !i_empty;
            lscn_pkg::BK_FINISH: load_out = !r_out_valid || o_result.ready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lscn_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // One restoring division step: one quotient bit per cycle.
    assign trial = {r_rem, r_quo[lscn_pkg::MAG_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem  <= '0;
            r_quo  <= i_entry.zero ? '0 : i_entry.mag;
            r_div  <= i_entry.span;
            r_neg  <= i_entry.neg;
            r_zero <= i_entry.zero;
            r_ch   <= i_entry.ch;
            r_cnt  <= '0;
        end else if (r_state == lscn_pkg::BK_DIVIDE) begin
            r_rem <= fits ? diff[lscn_pkg::SPAN_W-1:0] : trial[lscn_pkg::SPAN_W-1:0];
            r_quo <= {r_quo[lscn_pkg::MAG_W-2:0], fits};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Sign, saturation and zero span handling of the finished quotient.
    assign pos_sat = !r_neg && (r_quo > lscn_pkg::POS_LIMIT);
    assign neg_sat = r_neg && (r_quo > lscn_pkg::NEG_LIMIT);

    always_comb begin
        if (r_zero) begin
            pct    = '0;
            status = lscn_pkg::STATUS_ZERO_SPAN;
        end else if (pos_sat) begin
            pct    = lscn_pkg::PCT_MAX;
            status = lscn_pkg::STATUS_SAT;
        end else if (neg_sat) begin
            pct    = lscn_pkg::PCT_MIN;
            status = lscn_pkg::STATUS_SAT;
        end else if (r_neg) begin
            pct    = ~r_quo[lscn_pkg::PCT_W-1:0] + 16'd1;
            status = lscn_pkg::STATUS_OK;
        end else begin
            pct    = r_quo[lscn_pkg::PCT_W-1:0];
            status = lscn_pkg::STATUS_OK;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_pct    <= pct;
            r_status <= status;
            r_out_ch <= r_ch;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.percent        = $signed(r_pct);
    assign o_result.status         = r_status;
    assign o_result.result_channel = r_out_ch;

endmodule
